// File: sv/ctfc_pkg.sv
// ctfc_pkg: shared types and constants of the clock tree frequency calculator
// used by every module and interface of the block, depends on nothing
`default_nettype none
package ctfc_pkg;

    localparam int OSC_W    = 26;
    localparam int MUL_W    = 9;
    localparam int PRE_W    = 6;
    localparam int FREQ_W   = 35;
    localparam int TICK_W   = 32;
    localparam int DIVS_W   = 9;
    localparam int CELLS    = FREQ_W;
    localparam int CFG_IDX_W = 1;

    localparam logic [OSC_W-1:0] INT_OSC_RESET = 26'd16000000;
    localparam logic [OSC_W-1:0] EXT_OSC_RESET = 26'd8000000;

    localparam logic [CFG_IDX_W-1:0] REG_INT_OSC = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXT_OSC = 1'd1;

    localparam logic [1:0] SEL_INT  = 2'd0;
    localparam logic [1:0] SEL_EXT  = 2'd1;
    localparam logic [1:0] SEL_PLL  = 2'd2;
    localparam logic [1:0] SEL_NONE = 2'd3;

    typedef struct packed {
        logic       err;
        logic [3:0] ahb;
        logic [2:0] apb1;
        logic [2:0] apb2;
    } t_side;

    typedef struct packed {
        logic [DIVS_W-1:0] rem;
        logic [FREQ_W-1:0] dq;
        logic [DIVS_W-1:0] divisor;
        t_side             side;
    } t_div;

endpackage
`default_nettype wire

// File: sv/ctfc_in_if.sv
// ctfc_in_if: input item channel, one clock tree setting per item
// depends on ctfc_pkg
`default_nettype none
interface ctfc_in_if import ctfc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [1:0]       clock_select;
    logic             pll_from_external;
    logic [MUL_W-1:0] pll_multiplier;
    logic [PRE_W-1:0] pll_predivider;
    logic [1:0]       pll_post_code;
    logic [3:0]       ahb_prescale_code;
    logic [2:0]       apb1_prescale_code;
    logic [2:0]       apb2_prescale_code;

    modport source (
        output valid, clock_select, pll_from_external, pll_multiplier,
               pll_predivider, pll_post_code, ahb_prescale_code,
               apb1_prescale_code, apb2_prescale_code,
        input  ready
    );
    modport sink (
        input  valid, clock_select, pll_from_external, pll_multiplier,
               pll_predivider, pll_post_code, ahb_prescale_code,
               apb1_prescale_code, apb2_prescale_code,
        output ready
    );
endinterface
`default_nettype wire

// File: sv/ctfc_out_if.sv
// ctfc_out_if: result item channel, all derived frequencies of one setting
// depends on ctfc_pkg
`default_nettype none
interface ctfc_out_if import ctfc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FREQ_W-1:0] core_hz;
    logic [FREQ_W-1:0] apb1_hz;
    logic [FREQ_W-1:0] apb2_hz;
    logic [FREQ_W-1:0] apb1_timer_hz;
    logic [FREQ_W-1:0] apb2_timer_hz;
    logic [TICK_W-1:0] tick_timer_hz;
    logic              divide_error;

    modport source (
        output valid, core_hz, apb1_hz, apb2_hz, apb1_timer_hz, apb2_timer_hz,
               tick_timer_hz, divide_error,
        input  ready
    );
    modport sink (
        input  valid, core_hz, apb1_hz, apb2_hz, apb1_timer_hz, apb2_timer_hz,
               tick_timer_hz, divide_error,
        output ready
    );
endinterface
`default_nettype wire

// File: sv/ctfc_front.sv
// ctfc_front: oscillator registers, source select, pll product and divisor
// feeds the divider chain; depends on ctfc_pkg and ctfc_in_if
`default_nettype none
module ctfc_front import ctfc_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [OSC_W-1:0]     i_cfg_data,
    ctfc_in_if.sink                   i_in,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output t_div                      o_data
);

    logic [OSC_W-1:0]  r_int_osc;
    logic [OSC_W-1:0]  r_ext_osc;
    logic              r_valid;
    t_div              r_data;
    t_div              n_data;
    logic [OSC_W-1:0]  pll_src;
    logic [2:0]        post_factor;
    logic [PRE_W+2:0]  pre_scaled;
    logic              accept;

    assign i_in.ready = !r_valid || i_ready;
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int_osc <= INT_OSC_RESET;
            r_ext_osc <= EXT_OSC_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_INT_OSC: r_int_osc <= i_cfg_data;
                REG_EXT_OSC: r_ext_osc <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        pll_src     = i_in.pll_from_external ? r_ext_osc : r_int_osc;
        post_factor = {1'b0, i_in.pll_post_code} + 3'd1;
        pre_scaled  = {3'b0, i_in.pll_predivider} * {{PRE_W{1'b0}}, post_factor};
        n_data.rem       = '0;
        n_data.dq        = '0;
        n_data.divisor   = DIVS_W'(1);
        n_data.side.err  = 1'b0;
        n_data.side.ahb  = i_in.ahb_prescale_code;
        n_data.side.apb1 = i_in.apb1_prescale_code;
        n_data.side.apb2 = i_in.apb2_prescale_code;
        unique case (i_in.clock_select)
            SEL_INT: n_data.dq = FREQ_W'(r_int_osc);
            SEL_EXT: n_data.dq = FREQ_W'(r_ext_osc);
            SEL_PLL: begin
                if (i_in.pll_predivider == '0) begin
                    n_data.side.err = 1'b1;
                end else begin
                    n_data.dq      = {{(FREQ_W-OSC_W){1'b0}}, pll_src}
                                   * {{(FREQ_W-MUL_W){1'b0}}, i_in.pll_multiplier};
                    n_data.divisor = DIVS_W'({pre_scaled, 1'b0});
                end
            end
            SEL_NONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

// File: sv/ctfc_div_cell.sv
// ctfc_div_cell: one restoring division step, one quotient bit per cell
// depends on ctfc_pkg
`default_nettype none
module ctfc_div_cell import ctfc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_div i_data,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_div      o_data
);

    logic              r_valid;
    t_div              r_data;
    t_div              n_data;
    logic [DIVS_W:0]   rem_sh;
    logic              q_bit;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        rem_sh = {i_data.rem, i_data.dq[FREQ_W-1]};
        q_bit  = rem_sh >= {1'b0, i_data.divisor};
        n_data = i_data;
        n_data.rem = q_bit ? DIVS_W'(rem_sh - {1'b0, i_data.divisor})
                           : DIVS_W'(rem_sh);
        n_data.dq  = {i_data.dq[FREQ_W-2:0], q_bit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

// File: sv/ctfc_back.sv
// ctfc_back: prescaler shifts on the quotient and the result register
// depends on ctfc_pkg and ctfc_out_if
`default_nettype none
module ctfc_back import ctfc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_div i_data,
    ctfc_out_if.source o_out
);

    logic              r_valid;
    logic [FREQ_W-1:0] r_core;
    logic [FREQ_W-1:0] r_apb1;
    logic [FREQ_W-1:0] r_apb2;
    logic [FREQ_W-1:0] r_apb1_tim;
    logic [FREQ_W-1:0] r_apb2_tim;
    logic              r_err;
    logic [3:0]        ahb_sh;
    logic [FREQ_W-1:0] n_core;

    function automatic logic [FREQ_W-1:0] apb_div(
        input logic [FREQ_W-1:0] clk,
        input logic [2:0]        code,
        input logic [2:0]        base
    );
        logic [2:0] sh;
        sh = code - base;
        return code[2] ? (clk >> sh) : clk;
    endfunction

    assign o_ready = !r_valid || o_out.ready;

    always_comb begin
        ahb_sh = {1'b0, i_data.side.ahb[2:0]} + 4'd1;
        if (ahb_sh > 4'd4) begin
            ahb_sh = ahb_sh + 4'd1;
        end
        if (!i_data.side.ahb[3]) begin
            ahb_sh = 4'd0;
        end
        n_core = i_data.dq >> ahb_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_core     <= n_core;
            r_apb1     <= apb_div(n_core, i_data.side.apb1, 3'd3);
            r_apb2     <= apb_div(n_core, i_data.side.apb2, 3'd3);
            r_apb1_tim <= apb_div(n_core, i_data.side.apb1, 3'd2);
            r_apb2_tim <= apb_div(n_core, i_data.side.apb2, 3'd2);
            r_err      <= i_data.side.err;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.core_hz       = r_core;
    assign o_out.apb1_hz       = r_apb1;
    assign o_out.apb2_hz       = r_apb2;
    assign o_out.apb1_timer_hz = r_apb1_tim;
    assign o_out.apb2_timer_hz = r_apb2_tim;
    assign o_out.tick_timer_hz = r_core[FREQ_W-1:FREQ_W-TICK_W];
    assign o_out.divide_error  = r_err;

endmodule
`default_nettype wire

// File: sv/clock_tree_frequency_calc_unit.sv
// clock_tree_frequency_calc_unit: top level of the clock tree frequency calculator
// depends on ctfc_pkg, ctfc_in_if, ctfc_out_if, ctfc_front, ctfc_div_cell, ctfc_back
//
// usage
//   i_in carries one clock tree setting per item, o_out one result item with
//   every derived frequency. oscillator registers are written on the plain
//   port i_cfg_we / i_cfg_index / i_cfg_data while no item is in flight.
// pipeline and throughput
//   a result item passes these registers after its input item is accepted: the
//   accepting edge registers source select and the pll product, then 35 cells
//   of the divider chain (one quotient bit each, set by the 35-bit product
//   width), then the prescaler shifts and the result register.
//   one item is accepted every cycle while the chain moves.
// reset
//   the oscillator registers return to 16 MHz and 8 MHz and every stage is
//   emptied; items in flight are dropped, and none is produced by reset itself.
// stall
//   when o_out.ready is low the result holds; items behind it close up into
//   empty stages, and i_in.ready drops only once the whole chain is full.
`default_nettype none
module clock_tree_frequency_calc_unit import ctfc_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [OSC_W-1:0]     i_cfg_data,
    ctfc_in_if.sink                   i_in,
    ctfc_out_if.source                o_out
);

    logic chain_valid [CELLS+1];
    logic chain_ready [CELLS+1];
    t_div chain_data  [CELLS+1];

    ctfc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .o_valid     (chain_valid[0]),
        .i_ready     (chain_ready[0]),
        .o_data      (chain_data[0])
    );

    for (genvar k = 0; k < CELLS; k++) begin : g_cell
        ctfc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (chain_valid[k]),
            .o_ready (chain_ready[k]),
            .i_data  (chain_data[k]),
            .o_valid (chain_valid[k+1]),
            .i_ready (chain_ready[k+1]),
            .o_data  (chain_data[k+1])
        );
    end

    ctfc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (chain_valid[CELLS]),
        .o_ready (chain_ready[CELLS]),
        .i_data  (chain_data[CELLS]),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire

// File: tb/sv/clock_tree_frequency_calc_unit_tb.sv
`timescale 1ns / 1ps
// clock_tree_frequency_calc_unit_tb: checks every derived frequency of the clock tree
// calculator against an in-bench prediction, idling both channels at random, then not
// depends on ctfc_pkg, ctfc_in_if, ctfc_out_if and clock_tree_frequency_calc_unit
`default_nettype none
module clock_tree_frequency_calc_unit_tb;
    import ctfc_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 45;
    localparam logic [OSC_W-1:0] OSC_MAX = '1;

    typedef struct packed {
        logic [1:0]       sel;
        logic             pll_ext;
        logic [MUL_W-1:0] mul;
        logic [PRE_W-1:0] pre;
        logic [1:0]       post;
        logic [3:0]       ahb;
        logic [2:0]       apb1;
        logic [2:0]       apb2;
    } clk_setting_t;

    typedef struct packed {
        logic [FREQ_W-1:0] core;
        logic [FREQ_W-1:0] apb1;
        logic [FREQ_W-1:0] apb2;
        logic [FREQ_W-1:0] apb1_tim;
        logic [FREQ_W-1:0] apb2_tim;
        logic [TICK_W-1:0] tick;
        logic              err;
    } clk_freqs_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [OSC_W-1:0]     cfg_data;

    ctfc_in_if  in_if ();
    ctfc_out_if out_if ();

    clock_tree_frequency_calc_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    logic [OSC_W-1:0] int_osc_hz = INT_OSC_RESET;
    logic [OSC_W-1:0] ext_osc_hz = EXT_OSC_RESET;

    clk_setting_t pending_settings[$];
    clk_freqs_t   expected_freqs[$];
    clk_setting_t sent_setting;

    int  send_gap      = 0;
    int  recv_stall    = 0;
    bit  no_idle       = 0;
    int  fail_count    = 0;
    int  results_seen  = 0;
    int  error_results = 0;
    int  idle_cycles   = 0;
    int  osc_settings  = 1;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic logic [63:0] apb_clock(logic [63:0] clk, logic [2:0] code, int extra);
        if (code < 3'd4)
            return clk;
        return clk >> (int'(code) - 4 + extra);
    endfunction

    function automatic clk_freqs_t predict_freqs(clk_setting_t s);
        logic [63:0] clk;
        logic [63:0] src;
        int          sh;
        clk_freqs_t  r;
        r   = '0;
        clk = '0;
        src = s.pll_ext ? 64'(ext_osc_hz) : 64'(int_osc_hz);
        case (s.sel)
            SEL_INT: clk = 64'(int_osc_hz);
            SEL_EXT: clk = 64'(ext_osc_hz);
            SEL_PLL: begin
                if (s.pre == '0) begin
                    r.err = 1'b1;
                    return r;
                end
                clk = (src * 64'(s.mul)) / 64'(s.pre);
                clk = clk / (64'd2 * (64'(s.post) + 64'd1));
            end
            default: clk = '0;
        endcase
        if (s.ahb[3]) begin
            sh = int'(s.ahb[2:0]) + 1;
            if (sh > 4)
                sh = sh + 1;
            clk = clk >> sh;
        end
        r.core     = clk[FREQ_W-1:0];
        r.apb1     = FREQ_W'(apb_clock(clk, s.apb1, 1));
        r.apb2     = FREQ_W'(apb_clock(clk, s.apb2, 1));
        r.apb1_tim = FREQ_W'(apb_clock(clk, s.apb1, 2));
        r.apb2_tim = FREQ_W'(apb_clock(clk, s.apb2, 2));
        r.tick     = clk[TICK_W+2:3];
        return r;
    endfunction

    task automatic add_setting(logic [1:0] sel, int ext, int mul, int pre, int post,
                               int ahb, int apb1, int apb2);
        clk_setting_t s;
        s.sel     = sel;
        s.pll_ext = 1'(ext);
        s.mul     = MUL_W'(mul);
        s.pre     = PRE_W'(pre);
        s.post    = 2'(post);
        s.ahb     = 4'(ahb);
        s.apb1    = 3'(apb1);
        s.apb2    = 3'(apb2);
        pending_settings.push_back(s);
    endtask

    task automatic add_random_settings(int n);
        clk_setting_t s;
        int           pick;
        for (int k = 0; k < n; k++) begin
            pick      = $urandom_range(0, 7);
            s.sel     = (pick < 4) ? SEL_PLL : 2'(pick - 4);
            s.pll_ext = 1'($urandom_range(0, 1));
            s.mul     = MUL_W'($urandom_range(0, 511));
            s.pre     = ($urandom_range(0, 15) == 0) ? 6'd0 : 6'($urandom_range(1, 63));
            s.post    = 2'($urandom_range(0, 3));
            s.ahb     = 4'($urandom_range(0, 15));
            s.apb1    = 3'($urandom_range(0, 7));
            s.apb2    = 3'($urandom_range(0, 7));
            pending_settings.push_back(s);
        end
    endtask

    // caller holds off until every setting is sent and the block has drained completely
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_settings.size() != 0 || in_if.valid || expected_freqs.size() != 0);
    endtask

    task automatic write_osc(logic [CFG_IDX_W-1:0] idx, logic [OSC_W-1:0] value);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == REG_INT_OSC)
            int_osc_hz = value;
        else
            ext_osc_hz = value;
    endtask

    task automatic set_oscillators(logic [OSC_W-1:0] int_hz, logic [OSC_W-1:0] ext_hz);
        wait_drained();
        write_osc(REG_INT_OSC, int_hz);
        write_osc(REG_EXT_OSC, ext_hz);
        osc_settings++;
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            fail_count++;
            if (fail_count <= 10)
                $display("mismatch %s at %0t: expected %0d got %0d", name, $realtime, want, got);
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            send_gap    <= 0;
        end else begin
            if (in_if.valid && in_if.ready)
                expected_freqs.push_back(predict_freqs(sent_setting));
            if (!(in_if.valid && !in_if.ready)) begin
                if (send_gap > 0) begin
                    send_gap    <= send_gap - 1;
                    in_if.valid <= 1'b0;
                end else if (pending_settings.size() != 0) begin
                    sent_setting                = pending_settings.pop_front();
                    in_if.valid              <= 1'b1;
                    in_if.clock_select       <= sent_setting.sel;
                    in_if.pll_from_external  <= sent_setting.pll_ext;
                    in_if.pll_multiplier     <= sent_setting.mul;
                    in_if.pll_predivider     <= sent_setting.pre;
                    in_if.pll_post_code      <= sent_setting.post;
                    in_if.ahb_prescale_code  <= sent_setting.ahb;
                    in_if.apb1_prescale_code <= sent_setting.apb1;
                    in_if.apb2_prescale_code <= sent_setting.apb2;
                    if (!no_idle && $urandom_range(0, 5) == 0)
                        send_gap <= $urandom_range(1, 12);
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        clk_freqs_t want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            recv_stall   <= 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                results_seen++;
                if (expected_freqs.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result item at %0t", $realtime);
                end else begin
                    want = expected_freqs.pop_front();
                    if (want.err)
                        error_results++;
                    check_field("core_hz",       64'(want.core),     64'(out_if.core_hz));
                    check_field("apb1_hz",       64'(want.apb1),     64'(out_if.apb1_hz));
                    check_field("apb2_hz",       64'(want.apb2),     64'(out_if.apb2_hz));
                    check_field("apb1_timer_hz", 64'(want.apb1_tim),
                                64'(out_if.apb1_timer_hz));
                    check_field("apb2_timer_hz", 64'(want.apb2_tim),
                                64'(out_if.apb2_timer_hz));
                    check_field("tick_timer_hz", 64'(want.tick),
                                64'(out_if.tick_timer_hz));
                    check_field("divide_error",  64'(want.err),
                                64'(out_if.divide_error));
                end
            end
            if (recv_stall > 0) begin
                recv_stall   <= recv_stall - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
                if (!no_idle && $urandom_range(0, 4) == 0)
                    recv_stall <= $urandom_range(1, 12);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_INT_OSC;
        cfg_data     = '0;
        in_if.valid  = 1'b0;
        in_if.clock_select       = SEL_INT;
        in_if.pll_from_external  = 1'b0;
        in_if.pll_multiplier     = '0;
        in_if.pll_predivider     = '0;
        in_if.pll_post_code      = '0;
        in_if.ahb_prescale_code  = '0;
        in_if.apb1_prescale_code = '0;
        in_if.apb2_prescale_code = '0;
        out_if.ready = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed settings at reset oscillator values
        add_setting(SEL_INT,  0,   0,  0, 0,  0, 0, 0);
        add_setting(SEL_EXT,  1, 511, 63, 3, 15, 7, 7);
        add_setting(SEL_NONE, 1, 511, 63, 3,  8, 4, 4);
        add_setting(SEL_PLL,  0,   0,  5, 1,  0, 3, 3);
        add_setting(SEL_PLL,  1, 511,  0, 3, 15, 7, 7);
        add_setting(SEL_PLL,  0, 336,  0, 0,  0, 0, 0);
        add_setting(SEL_INT,  0, 100,  0, 2,  9, 5, 6);
        add_setting(SEL_PLL,  1, 511,  1, 0,  0, 0, 0);
        add_setting(SEL_PLL,  0, 511,  1, 0, 10, 4, 7);
        add_setting(SEL_PLL,  1, 336,  8, 0, 11, 5, 4);
        add_setting(SEL_PLL,  0,   1, 63, 3, 12, 6, 5);
        add_setting(SEL_PLL,  1, 168,  4, 1, 13, 7, 4);
        add_setting(SEL_PLL,  0, 432, 25, 2, 14, 4, 6);
        add_setting(SEL_EXT,  0,   0,  0, 0, 15, 0, 7);
        add_setting(SEL_INT,  1,   0,  0, 0,  8, 1, 2);
        add_setting(SEL_EXT,  0,   0,  0, 0, 12, 2, 3);
        add_setting(SEL_NONE, 0,   0,  0, 0,  0, 7, 7);
        add_random_settings(250);

        set_oscillators(OSC_MAX, OSC_MAX);
        add_setting(SEL_PLL, 0, 511, 1, 0,  0, 7, 7);
        add_setting(SEL_PLL, 1, 511, 1, 0, 15, 4, 4);
        add_setting(SEL_EXT, 0,   0, 0, 0,  0, 6, 7);
        add_random_settings(250);

        set_oscillators('0, '0);
        add_random_settings(200);

        set_oscillators(OSC_MAX, '0);
        add_random_settings(250);

        set_oscillators(OSC_W'($urandom_range(0, 67108863)),
                        OSC_W'($urandom_range(0, 67108863)));
        add_random_settings(300);

        set_oscillators(26'd25000000, 26'd12000000);
        add_random_settings(300);

        // closing stretch runs at full rate on both channels
        wait_drained();
        no_idle = 1'b1;
        add_random_settings(250);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        if (expected_freqs.size() != 0) begin
            fail_count += expected_freqs.size();
            $display("%0d expected result items never arrived", expected_freqs.size());
        end
        $display("checked %0d result items (%0d with divide error) over %0d oscillator settings",
                 results_seen, error_results, osc_settings);
        $display("random idling on both channels, full-rate closing stretch, %0d failures",
                 fail_count);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
`default_nettype wire
